>>> src/text_length_and_letter_histogram_top_assert.svh
// assertion macros for the text histogram block
`ifndef TEXT_LENGTH_AND_LETTER_HISTOGRAM_TOP_ASSERT_SVH
`define TEXT_LENGTH_AND_LETTER_HISTOGRAM_TOP_ASSERT_SVH

// same-cycle implication
`define TLH_ASSERT_SAME(label, cond, prop) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond) |-> (prop)) \
        else $error("text histogram: same-cycle check failed");

// next-cycle implication
`define TLH_ASSERT_NEXT(label, cond, prop) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond) |=> (prop)) \
        else $error("text histogram: next-cycle check failed");

`endif

>>> src/tlh_pkg.sv
// shared types and constants of the text histogram block
package tlh_pkg;

    localparam int OUT_W       = 32;
    localparam int LETTER_BINS = 26;
    localparam int FEATURE_W   = 7;
    localparam int CFG_INDEX_W = 1;

    localparam logic [1:0] OP_CLEAR = 2'd0;
    localparam logic [1:0] OP_BYTE  = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    localparam logic [1:0] SEL_SENTENCE  = 2'd0;
    localparam logic [1:0] SEL_LETTER    = 2'd1;
    localparam logic [1:0] SEL_PARAGRAPH = 2'd2;

    localparam logic [CFG_INDEX_W-1:0] CFG_PARAGRAPH_ENABLE = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_FEATURE_LENGTH   = 1'd1;

    localparam logic [FEATURE_W-1:0] FEATURE_RESET = 7'd64;

    localparam int SENT_DIV     = 10;
    localparam int PARA_DIV     = 100;
    // x / 10 == (x * 205) >> 11 for x below 1029
    localparam int SENT_RECIP   = 205;
    localparam int SENT_RECIP_W = 8;
    localparam int SENT_SHIFT   = 11;
    // x / 100 == (x * 5243) >> 19 for x below 43699
    localparam int PARA_RECIP   = 5243;
    localparam int PARA_RECIP_W = 13;
    localparam int PARA_SHIFT   = 19;

    localparam logic [7:0] CH_PERIOD   = 8'h2E;
    localparam logic [7:0] CH_BANG     = 8'h21;
    localparam logic [7:0] CH_QUESTION = 8'h3F;
    localparam logic [7:0] CH_NEWLINE  = 8'h0A;
    localparam logic [7:0] CH_UPPER_A  = 8'h41;
    localparam logic [7:0] CH_UPPER_Z  = 8'h5A;
    localparam logic [7:0] CH_LOWER_A  = 8'h61;
    localparam logic [7:0] CH_LOWER_Z  = 8'h7A;
    localparam logic [7:0] CASE_OFFSET = 8'h20;

    typedef struct packed {
        logic [OUT_W-1:0] bin_count;
        logic [OUT_W-1:0] histogram_total;
        logic             index_valid;
    } result_t;

endpackage

>>> src/tlh_ram.sv
// generic ram, one write port and two registered read ports
module tlh_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr_a,
    output logic [WIDTH-1:0] rdata_a,
    input  logic [AW-1:0]    raddr_b,
    output logic [WIDTH-1:0] rdata_b
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_a <= mem_reg[raddr_a];
            rdata_b <= mem_reg[raddr_b];
        end
    end

endmodule

>>> src/text_length_and_letter_histogram_top.sv
// Sentence length, letter and paragraph length histograms over a text byte stream.
// Throughput: one request per cycle; input stalls only while the output skid slot is full.
// A read request's result passes through the input register, the bin lookup register
// and the output register.
// Paragraph bins live in a ram read from the input stage, with write forwarding for neighbors.
// Reset (synchronous, aresetn low) zeroes all counts at once; no clearing pass.
`include "text_length_and_letter_histogram_top_assert.svh"

module text_length_and_letter_histogram_top #(
    parameter int SENTENCE_BINS  = 20,
    parameter int PARAGRAPH_BINS = 50,
    parameter int COUNT_WIDTH    = 32
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    // request channel
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [15:0]                          s_tdata,   // text_byte, bin_index, pad
    input  logic [3:0]                           s_tuser,   // operation, histogram_select
    // result channel
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [63:0]                          m_tdata,   // bin_count, histogram_total
    output logic [0:0]                           m_tuser,   // index_valid
    // configuration
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [tlh_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  logic [tlh_pkg::FEATURE_W-1:0]        cfg_data
);

    localparam int CW       = COUNT_WIDTH;
    localparam int SBW      = $clog2(SENTENCE_BINS);
    localparam int PAW      = $clog2(PARAGRAPH_BINS);
    localparam int LBW      = $clog2(tlh_pkg::LETTER_BINS);
    localparam int SENT_SAT = tlh_pkg::SENT_DIV * (SENTENCE_BINS - 1);
    localparam int PARA_SAT = tlh_pkg::PARA_DIV * (PARAGRAPH_BINS - 1);
    localparam int SXW      = $clog2(SENT_SAT + 1);
    localparam int PXW      = $clog2(PARA_SAT + 1);
    localparam int SPW      = SXW + tlh_pkg::SENT_RECIP_W;
    localparam int PPW      = PXW + tlh_pkg::PARA_RECIP_W;

    function automatic logic [CW-1:0] sat_inc(input logic [CW-1:0] v);
        return (v == {CW{1'b1}}) ? v : v + CW'(1);
    endfunction

    // configuration
    logic                          paragraph_enable_reg;
    logic [tlh_pkg::FEATURE_W-1:0] feature_length_reg;

    // input register
    logic       s1_valid_reg;
    logic [1:0] s1_op_reg;
    logic [7:0] s1_byte_reg;
    logic [1:0] s1_sel_reg;
    logic [5:0] s1_idx_reg;

    // histogram state
    logic [CW-1:0]             sentence_run_reg, sentence_run_next;
    logic [CW-1:0]             para_run_reg, para_run_next;
    logic                      prev_nl_reg, prev_nl_next;
    logic [CW-1:0]             sentence_total_reg, sentence_total_next;
    logic [CW-1:0]             letter_total_reg, letter_total_next;
    logic [CW-1:0]             paragraph_total_reg, paragraph_total_next;
    logic [CW-1:0]             sentence_bins_reg [SENTENCE_BINS];
    logic [CW-1:0]             sentence_bins_next [SENTENCE_BINS];
    logic [CW-1:0]             letter_bins_reg [tlh_pkg::LETTER_BINS];
    logic [CW-1:0]             letter_bins_next [tlh_pkg::LETTER_BINS];
    logic [PARAGRAPH_BINS-1:0] para_valid_reg, para_valid_next;

    // lookup stage
    logic                 s2_valid_reg;
    tlh_pkg::result_t     s2_res_reg, s2_res_next;
    logic                 s2_para_sel_reg, s2_para_sel_next;
    logic                 s2_b_valid_reg;
    logic                 s2_fwd_b_reg, s2_fwd_b_next;
    logic [CW-1:0]        s2_fwd_b_data_reg;
    logic                 s2_wr_reg;
    logic [PAW-1:0]       s2_waddr_reg;
    logic                 s2_a_valid_reg;
    logic                 s2_fwd_a_reg, s2_fwd_a_next;
    logic [CW-1:0]        s2_fwd_a_data_reg;

    // output register and skid slot
    tlh_pkg::result_t m_res_reg, skid_res_reg, push_res;
    logic             m_tvalid_reg, skid_valid_reg;

    logic adv, s_accept, s1_clear, s1_byte, s1_read, push;

    // byte decode
    logic [CW-1:0]  sent_run_inc;
    logic           is_term, is_letter, is_nl, para_event;
    logic [7:0]     folded;
    logic [LBW-1:0] letter_idx;
    logic [SXW-1:0] sent_x;
    logic [SPW-1:0] sent_prod;
    logic [SBW-1:0] sent_bucket;
    logic [PXW-1:0] para_x;
    logic [PPW-1:0] para_prod;
    logic [PAW-1:0] para_bucket;

    // read decode
    logic           fl_ok, sent_ok, letter_ok, para_ok;
    logic [PAW-1:0] rb_addr;

    // paragraph ram
    logic           ram_we;
    logic [CW-1:0]  ram_wdata, ram_q_a, ram_q_b, para_a, para_b;

    assign adv       = !skid_valid_reg;
    assign s_tready  = adv;
    assign s_accept  = s_tvalid && adv;
    assign cfg_ready = 1'b1;
    assign s1_clear  = adv && s1_valid_reg && (s1_op_reg == tlh_pkg::OP_CLEAR);
    assign s1_byte   = adv && s1_valid_reg && (s1_op_reg == tlh_pkg::OP_BYTE);
    assign s1_read   = adv && s1_valid_reg && (s1_op_reg == tlh_pkg::OP_READ);

    always_comb begin
        sent_run_inc = sat_inc(sentence_run_reg);
        is_term = (s1_byte_reg == tlh_pkg::CH_PERIOD) || (s1_byte_reg == tlh_pkg::CH_BANG)
               || (s1_byte_reg == tlh_pkg::CH_QUESTION);
        sent_x    = SXW'(sent_run_inc);
        sent_prod = SPW'(sent_x) * SPW'(tlh_pkg::SENT_RECIP);
        if (64'(sent_run_inc) >= 64'(SENT_SAT)) begin
            sent_bucket = SBW'(SENTENCE_BINS - 1);
        end else begin
            sent_bucket = SBW'(sent_prod >> tlh_pkg::SENT_SHIFT);
        end

        if (s1_byte_reg >= tlh_pkg::CH_UPPER_A && s1_byte_reg <= tlh_pkg::CH_UPPER_Z) begin
            folded = s1_byte_reg + tlh_pkg::CASE_OFFSET;
        end else begin
            folded = s1_byte_reg;
        end
        is_letter  = (folded >= tlh_pkg::CH_LOWER_A) && (folded <= tlh_pkg::CH_LOWER_Z);
        letter_idx = LBW'(folded - tlh_pkg::CH_LOWER_A);

        is_nl      = (s1_byte_reg == tlh_pkg::CH_NEWLINE);
        para_event = paragraph_enable_reg && prev_nl_reg && is_nl;
        para_x     = PXW'(para_run_reg);
        para_prod  = PPW'(para_x) * PPW'(tlh_pkg::PARA_RECIP);
        if (64'(para_run_reg) >= 64'(PARA_SAT)) begin
            para_bucket = PAW'(PARAGRAPH_BINS - 1);
        end else begin
            para_bucket = PAW'(para_prod >> tlh_pkg::PARA_SHIFT);
        end
    end

    // paragraph bin read-modify-write
    always_comb begin
        para_a    = s2_fwd_a_reg ? s2_fwd_a_data_reg : (s2_a_valid_reg ? ram_q_a : '0);
        para_b    = s2_fwd_b_reg ? s2_fwd_b_data_reg : (s2_b_valid_reg ? ram_q_b : '0);
        ram_wdata = sat_inc(para_a);
        ram_we    = adv && s2_wr_reg && !s1_clear;
        rb_addr   = PAW'(s1_idx_reg);
        s2_fwd_a_next = ram_we && (s2_waddr_reg == para_bucket);
        s2_fwd_b_next = ram_we && (s2_waddr_reg == rb_addr);
    end

    tlh_ram #(
        .WIDTH (CW),
        .DEPTH (PARAGRAPH_BINS)
    ) u_para_ram (
        .aclk    (aclk),
        .we      (ram_we),
        .waddr   (s2_waddr_reg),
        .wdata   (ram_wdata),
        .re      (adv),
        .raddr_a (para_bucket),
        .rdata_a (ram_q_a),
        .raddr_b (rb_addr),
        .rdata_b (ram_q_b)
    );

    // state update
    always_comb begin
        sentence_run_next    = sentence_run_reg;
        para_run_next        = para_run_reg;
        prev_nl_next         = prev_nl_reg;
        sentence_total_next  = sentence_total_reg;
        letter_total_next    = letter_total_reg;
        paragraph_total_next = paragraph_total_reg;
        sentence_bins_next   = sentence_bins_reg;
        letter_bins_next     = letter_bins_reg;
        para_valid_next      = para_valid_reg;

        if (s1_clear) begin
            sentence_run_next    = '0;
            para_run_next        = '0;
            prev_nl_next         = 1'b0;
            sentence_total_next  = '0;
            letter_total_next    = '0;
            paragraph_total_next = '0;
            para_valid_next      = '0;
            for (int i = 0; i < SENTENCE_BINS; i++) begin
                sentence_bins_next[i] = '0;
            end
            for (int i = 0; i < tlh_pkg::LETTER_BINS; i++) begin
                letter_bins_next[i] = '0;
            end
        end else if (s1_byte) begin
            sentence_run_next = is_term ? '0 : sent_run_inc;
            if (is_term) begin
                sentence_total_next = sat_inc(sentence_total_reg);
                for (int i = 0; i < SENTENCE_BINS; i++) begin
                    if (SBW'(i) == sent_bucket) begin
                        sentence_bins_next[i] = sat_inc(sentence_bins_reg[i]);
                    end
                end
            end
            if (is_letter) begin
                letter_total_next = sat_inc(letter_total_reg);
                for (int i = 0; i < tlh_pkg::LETTER_BINS; i++) begin
                    if (LBW'(i) == letter_idx) begin
                        letter_bins_next[i] = sat_inc(letter_bins_reg[i]);
                    end
                end
            end
            if (paragraph_enable_reg) begin
                prev_nl_next  = is_nl;
                para_run_next = para_event ? CW'(1) : sat_inc(para_run_reg);
                if (para_event) begin
                    paragraph_total_next = sat_inc(paragraph_total_reg);
                end
            end
        end

        if (ram_we) begin
            para_valid_next[s2_waddr_reg] = 1'b1;
        end
    end

    // bin lookup for read requests
    always_comb begin
        fl_ok     = {1'b0, s1_idx_reg} < feature_length_reg;
        sent_ok   = {1'b0, s1_idx_reg} < 7'(SENTENCE_BINS);
        letter_ok = {1'b0, s1_idx_reg} < 7'(tlh_pkg::LETTER_BINS);
        para_ok   = {1'b0, s1_idx_reg} < 7'(PARAGRAPH_BINS);
        s2_res_next      = '0;
        s2_para_sel_next = 1'b0;
        case (s1_sel_reg)
            tlh_pkg::SEL_SENTENCE: begin
                s2_res_next.histogram_total = tlh_pkg::OUT_W'(sentence_total_reg);
                s2_res_next.index_valid     = sent_ok && fl_ok;
                if (sent_ok && fl_ok) begin
                    s2_res_next.bin_count =
                        tlh_pkg::OUT_W'(sentence_bins_reg[SBW'(s1_idx_reg)]);
                end
            end
            tlh_pkg::SEL_LETTER: begin
                s2_res_next.histogram_total = tlh_pkg::OUT_W'(letter_total_reg);
                s2_res_next.index_valid     = letter_ok && fl_ok;
                if (letter_ok && fl_ok) begin
                    s2_res_next.bin_count =
                        tlh_pkg::OUT_W'(letter_bins_reg[LBW'(s1_idx_reg)]);
                end
            end
            tlh_pkg::SEL_PARAGRAPH: begin
                s2_res_next.histogram_total =
                    paragraph_enable_reg ? tlh_pkg::OUT_W'(paragraph_total_reg) : '0;
                s2_res_next.index_valid = para_ok && fl_ok;
                s2_para_sel_next        = para_ok && fl_ok && paragraph_enable_reg;
            end
            default: begin
                s2_res_next = '0;
            end
        endcase
    end

    always_comb begin
        push_res = s2_res_reg;
        if (s2_para_sel_reg) begin
            push_res.bin_count = tlh_pkg::OUT_W'(para_b);
        end
        push = adv && s2_valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            paragraph_enable_reg <= 1'b1;
            feature_length_reg   <= tlh_pkg::FEATURE_RESET;
            s1_valid_reg         <= 1'b0;
            sentence_run_reg     <= '0;
            para_run_reg         <= '0;
            prev_nl_reg          <= 1'b0;
            sentence_total_reg   <= '0;
            letter_total_reg     <= '0;
            paragraph_total_reg  <= '0;
            sentence_bins_reg    <= '{default: '0};
            letter_bins_reg      <= '{default: '0};
            para_valid_reg       <= '0;
            s2_valid_reg         <= 1'b0;
            s2_wr_reg            <= 1'b0;
            m_tvalid_reg         <= 1'b0;
            skid_valid_reg       <= 1'b0;
        end else begin
            if (cfg_valid) begin
                case (cfg_index)
                    tlh_pkg::CFG_PARAGRAPH_ENABLE: paragraph_enable_reg <= cfg_data[0];
                    tlh_pkg::CFG_FEATURE_LENGTH:   feature_length_reg   <= cfg_data;
                    default: begin
                    end
                endcase
            end

            if (adv) begin
                s1_valid_reg <= s_accept;
                s2_valid_reg <= s1_read;
                s2_wr_reg    <= s1_byte && para_event;
            end

            sentence_run_reg    <= sentence_run_next;
            para_run_reg        <= para_run_next;
            prev_nl_reg         <= prev_nl_next;
            sentence_total_reg  <= sentence_total_next;
            letter_total_reg    <= letter_total_next;
            paragraph_total_reg <= paragraph_total_next;
            sentence_bins_reg   <= sentence_bins_next;
            letter_bins_reg     <= letter_bins_next;
            para_valid_reg      <= para_valid_next;

            if (!m_tvalid_reg || m_tready) begin
                if (skid_valid_reg) begin
                    m_tvalid_reg   <= 1'b1;
                    skid_valid_reg <= 1'b0;
                end else begin
                    m_tvalid_reg <= push;
                end
            end else if (push) begin
                skid_valid_reg <= 1'b1;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (adv) begin
            s1_op_reg         <= s_tuser[1:0];
            s1_sel_reg        <= s_tuser[3:2];
            s1_byte_reg       <= s_tdata[7:0];
            s1_idx_reg        <= s_tdata[13:8];
            s2_res_reg        <= s2_res_next;
            s2_para_sel_reg   <= s2_para_sel_next;
            s2_b_valid_reg    <= para_valid_reg[rb_addr];
            s2_fwd_b_reg      <= s2_fwd_b_next;
            s2_fwd_b_data_reg <= ram_wdata;
            s2_waddr_reg      <= para_bucket;
            s2_a_valid_reg    <= para_valid_reg[para_bucket];
            s2_fwd_a_reg      <= s2_fwd_a_next;
            s2_fwd_a_data_reg <= ram_wdata;
        end
        if (!m_tvalid_reg || m_tready) begin
            m_res_reg <= skid_valid_reg ? skid_res_reg : push_res;
        end else if (push) begin
            skid_res_reg <= push_res;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {m_res_reg.histogram_total, m_res_reg.bin_count};
    assign m_tuser  = m_res_reg.index_valid;

    `TLH_ASSERT_SAME(a_skid_behind_output, skid_valid_reg, m_tvalid_reg)
    `TLH_ASSERT_NEXT(a_clear_zeroes_state, s1_clear, sentence_total_reg == '0 && letter_total_reg == '0 && para_valid_reg == '0)
    `TLH_ASSERT_NEXT(a_sentence_total_grows, !s1_clear, sentence_total_reg >= $past(sentence_total_reg))
    `TLH_ASSERT_NEXT(a_paragraph_frozen_off, !paragraph_enable_reg && !s1_clear, $stable(paragraph_total_reg) && $stable(para_run_reg))

endmodule
